@@ rtl/mcct_pkg.sv @@
// Shared types, codes and constants of the multi-channel countdown timer.
`timescale 1ns / 1ps
`default_nettype none
package mcct_pkg;

  // Default configuration
  localparam int NUM_CHANNELS_DEF = 4;
  localparam int COUNT_BITS_DEF   = 24;

  // Field widths of the stream beats
  localparam int REQ_W       = 2;
  localparam int CHAN_W      = 2;
  localparam int REG_W       = 3;
  localparam int DATA_W      = 32;
  localparam int IRQ_W       = 4;
  localparam int CHAN_ID_W   = 4;
  localparam int SEL_SLOTS   = 1 << CHAN_W;
  localparam int IN_TDATA_W  = 40;
  localparam int OUT_TDATA_W = 40;

  // Interval register: immediate load flag
  localparam int LOAD_BIT = 31;

  // Control register: repeat mode code
  localparam logic [1:0] MODE_REPEAT = 2'd0;

  // Request kinds
  typedef enum logic [REQ_W-1:0] {
    REQ_TICK  = 2'd0,
    REQ_WRITE = 2'd1,
    REQ_READ  = 2'd2
  } req_e;

  // Register addresses
  localparam logic [REG_W-1:0] REG_INTERVAL = 3'd0;
  localparam logic [REG_W-1:0] REG_CONTROL  = 3'd1;
  localparam logic [REG_W-1:0] REG_STATUS   = 3'd2;
  localparam logic [REG_W-1:0] REG_IDLE     = 3'd3;
  localparam logic [REG_W-1:0] REG_IRQ      = 3'd4;
  localparam logic [REG_W-1:0] REG_COUNT    = 3'd5;

  // Per-channel update commands for one beat
  typedef struct packed {
    logic tick;
    logic wr_interval;
    logic wr_control;
    logic clr_flag;
    logic clr_use;
    logic claim;
  } chan_ctrl_t;

  // Per-channel flags seen by the register file
  typedef struct packed {
    logic       running;
    logic       in_use;
    logic       tflag;
    logic       int_en;
    logic [1:0] mode;
  } chan_stat_t;

endpackage
`default_nettype wire

@@ rtl/mcct_channel.sv @@
// One timer channel: counter, reload value, mode and flags.
`timescale 1ns / 1ps
`default_nettype none
module mcct_channel #(
  parameter int COUNT_BITS = mcct_pkg::COUNT_BITS_DEF
) (
  input  wire logic                       clk,
  input  wire logic                       rst,
  input  wire mcct_pkg::chan_ctrl_t       ctrl,
  input  wire logic [mcct_pkg::DATA_W-1:0] wdata,
  output mcct_pkg::chan_stat_t            stat,
  output logic [COUNT_BITS-1:0]           count,
  output logic [COUNT_BITS-1:0]           reload,
  output logic                            irq_next
);
  import mcct_pkg::*;

  logic [COUNT_BITS-1:0] count_next;
  logic [COUNT_BITS-1:0] reload_next;
  logic [COUNT_BITS-1:0] wr_val;
  chan_stat_t            stat_next;

  assign wr_val = wdata[COUNT_BITS-1:0];

  // Work out this beat's channel update
  always_comb begin
    count_next  = count;
    reload_next = reload;
    stat_next   = stat;
    if (ctrl.tick) begin
      if (stat.running) begin
        if (count <= COUNT_BITS'(1)) begin
          stat_next.tflag = 1'b1;
          if (stat.mode == MODE_REPEAT) begin
            count_next        = reload;
            stat_next.running = (reload != '0);
          end else begin
            count_next        = '0;
            stat_next.running = 1'b0;
          end
        end else begin
          count_next = count - COUNT_BITS'(1);
        end
      end
    end else if (ctrl.wr_interval) begin
      reload_next = wr_val;
      if (wdata[LOAD_BIT] || !stat.running) begin
        count_next        = wr_val;
        stat_next.running = (wr_val != '0);
      end
    end else if (ctrl.wr_control) begin
      stat_next.int_en = wdata[0];
      stat_next.mode   = wdata[2:1];
    end else begin
      if (ctrl.clr_flag) begin
        stat_next.tflag = 1'b0;
      end
      if (ctrl.clr_use) begin
        stat_next.in_use = 1'b0;
      end
      if (ctrl.claim) begin
        stat_next.in_use = 1'b1;
      end
    end
  end

  assign irq_next = stat_next.tflag & stat_next.int_en;

  // Hold channel state
  always_ff @(posedge clk) begin
    if (rst) begin
      count  <= '0;
      reload <= '0;
      stat   <= '0;
    end else begin
      count  <= count_next;
      reload <= reload_next;
      stat   <= stat_next;
    end
  end

endmodule
`default_nettype wire

@@ rtl/mcct_idle.sv @@
// Lowest free channel finder for the idle-channel register.
`timescale 1ns / 1ps
`default_nettype none
module mcct_idle #(
  parameter int NUM_CHANNELS = mcct_pkg::NUM_CHANNELS_DEF
) (
  input  wire logic [NUM_CHANNELS-1:0]        free,
  output logic [mcct_pkg::CHAN_ID_W-1:0]      idle_id,
  output logic [NUM_CHANNELS-1:0]             first_free
);
  import mcct_pkg::*;

  // Scan from the top so the lowest free channel wins
  always_comb begin
    idle_id    = CHAN_ID_W'(NUM_CHANNELS);
    first_free = '0;
    for (int i = NUM_CHANNELS - 1; i >= 0; i--) begin
      if (free[i]) begin
        idle_id    = CHAN_ID_W'(i);
        first_free = '0;
        first_free[i] = 1'b1;
      end
    end
  end

endmodule
`default_nettype wire

@@ rtl/multi_channel_countdown_timer.sv @@
// Top level: stream handshake, request decode, register reads and timer channels.
// Throughput: one beat per cycle while the result stream is not stalled;
// ticks, writes and reads all go back to back.
// The decode and channel update sit between the input register and the result
// register, so every channel counts in the same cycle.
// Reset (rst, synchronous): clears all channel state, multitask mode and both stages.
`timescale 1ns / 1ps
`default_nettype none
module multi_channel_countdown_timer #(
  parameter int NUM_CHANNELS = mcct_pkg::NUM_CHANNELS_DEF,
  parameter int COUNT_BITS   = mcct_pkg::COUNT_BITS_DEF
) (
  input  wire logic                              clk,
  input  wire logic                              rst,
  // Configuration write: bit 0 multitask_mode
  input  wire logic                              cfg_valid,
  output logic                                   cfg_ready,
  input  wire logic                              cfg_data,
  // Request stream
  input  wire logic                              s_axis_tvalid,
  output logic                                   s_axis_tready,
  // tdata: chan_sel [1:0], reg_sel [4:2], wdata [36:5], zero [39:37]
  input  wire logic [mcct_pkg::IN_TDATA_W-1:0]   s_axis_tdata,
  // tuser: req_type [1:0]
  input  wire logic [mcct_pkg::REQ_W-1:0]        s_axis_tuser,
  // Result stream
  output logic                                   m_axis_tvalid,
  input  wire logic                              m_axis_tready,
  // tdata: read_data [31:0], irq_lines [35:32], zero [39:36]
  output logic [mcct_pkg::OUT_TDATA_W-1:0]       m_axis_tdata
);
  import mcct_pkg::*;

  // Input register
  logic                    in_valid;
  logic [REQ_W-1:0]        in_req;
  logic [CHAN_W-1:0]       in_chan;
  logic [REG_W-1:0]        in_reg;
  logic [DATA_W-1:0]       in_wdata;

  // Result register
  logic                    out_valid;
  logic [DATA_W-1:0]       out_read_data;
  logic [IRQ_W-1:0]        out_irq;

  logic                    multitask;
  logic                    s_accept;
  logic                    advance;

  logic                    is_tick;
  logic                    is_write;
  logic                    is_read;
  logic                    chan_ok;
  logic                    do_claim;

  chan_ctrl_t              ctrl    [NUM_CHANNELS];
  chan_stat_t              stat    [NUM_CHANNELS];
  logic [COUNT_BITS-1:0]   count   [NUM_CHANNELS];
  logic [COUNT_BITS-1:0]   reload  [NUM_CHANNELS];
  logic [NUM_CHANNELS-1:0] irq_vec;
  logic [NUM_CHANNELS-1:0] tflag_vec;
  logic [NUM_CHANNELS-1:0] free_vec;
  logic [NUM_CHANNELS-1:0] first_free;
  logic [NUM_CHANNELS-1:0] claim_vec;
  logic [CHAN_ID_W-1:0]    idle_id;

  chan_stat_t              slot_stat   [SEL_SLOTS];
  logic [DATA_W-1:0]       slot_count  [SEL_SLOTS];
  logic [DATA_W-1:0]       slot_reload [SEL_SLOTS];
  logic [IRQ_W-1:0]        irq_lines;
  logic [DATA_W-1:0]       read_data;

  // Handshake: take a beat whenever the input register is empty or moving on
  assign advance       = in_valid && (!out_valid || m_axis_tready);
  assign s_axis_tready = !in_valid || advance;
  assign s_accept      = s_axis_tvalid && s_axis_tready;
  assign cfg_ready     = 1'b1;

  // Multitask mode register
  always_ff @(posedge clk) begin
    if (rst) begin
      multitask <= 1'b0;
    end else if (cfg_valid && cfg_ready) begin
      multitask <= cfg_data;
    end
  end

  // Input register
  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (s_accept) begin
      in_valid <= 1'b1;
    end else if (advance) begin
      in_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s_accept) begin
      in_req   <= s_axis_tuser;
      in_chan  <= s_axis_tdata[CHAN_W-1:0];
      in_reg   <= s_axis_tdata[CHAN_W+REG_W-1:CHAN_W];
      in_wdata <= s_axis_tdata[CHAN_W+REG_W+DATA_W-1:CHAN_W+REG_W];
    end
  end

  // Decode the request
  assign is_tick  = advance && (in_req == REQ_TICK);
  assign is_write = advance && (in_req == REQ_WRITE);
  assign is_read  = advance && (in_req == REQ_READ);
  assign chan_ok  = {{(CHAN_ID_W-CHAN_W){1'b0}}, in_chan} < CHAN_ID_W'(NUM_CHANNELS);
  assign do_claim = is_read && (in_reg == REG_IDLE) && multitask;
  assign claim_vec = do_claim ? first_free : '0;

  // Channels
  for (genvar c = 0; c < NUM_CHANNELS; c++) begin : g_chan
    logic sel;
    assign sel = chan_ok &&
                 ({{(CHAN_ID_W-CHAN_W){1'b0}}, in_chan} == CHAN_ID_W'(c));

    always_comb begin
      ctrl[c].tick        = is_tick;
      ctrl[c].wr_interval = is_write && sel && (in_reg == REG_INTERVAL);
      ctrl[c].wr_control  = is_write && sel && (in_reg == REG_CONTROL);
      ctrl[c].clr_flag    = (is_write && (in_reg == REG_IRQ) && in_wdata[c]) ||
                            (is_write && sel && (in_reg == REG_STATUS) && in_wdata[0]);
      ctrl[c].clr_use     = is_write && sel && (in_reg == REG_STATUS) && in_wdata[2];
      ctrl[c].claim       = claim_vec[c];
    end

    mcct_channel #(
      .COUNT_BITS(COUNT_BITS)
    ) u_channel (
      .clk      (clk),
      .rst      (rst),
      .ctrl     (ctrl[c]),
      .wdata    (in_wdata),
      .stat     (stat[c]),
      .count    (count[c]),
      .reload   (reload[c]),
      .irq_next (irq_vec[c])
    );

    assign tflag_vec[c] = stat[c].tflag;
    assign free_vec[c]  = !stat[c].running && !stat[c].in_use;
  end

  mcct_idle #(
    .NUM_CHANNELS(NUM_CHANNELS)
  ) u_idle (
    .free       (free_vec),
    .idle_id    (idle_id),
    .first_free (first_free)
  );

  // Map addressable channels onto selector slots; missing ones read as zero
  for (genvar s = 0; s < SEL_SLOTS; s++) begin : g_slot
    if (s < NUM_CHANNELS) begin : g_live
      assign slot_stat[s]   = stat[s];
      assign slot_count[s]  = {{(DATA_W-COUNT_BITS){1'b0}}, count[s]};
      assign slot_reload[s] = {{(DATA_W-COUNT_BITS){1'b0}}, reload[s]};
      assign irq_lines[s]   = irq_vec[s];
    end else begin : g_none
      assign slot_stat[s]   = '0;
      assign slot_count[s]  = '0;
      assign slot_reload[s] = '0;
      assign irq_lines[s]   = 1'b0;
    end
  end

  // Register read mux
  always_comb begin
    read_data = '0;
    if (is_read) begin
      unique case (in_reg)
        REG_INTERVAL: read_data = slot_reload[in_chan];
        REG_CONTROL:  read_data = {{(DATA_W-3){1'b0}}, slot_stat[in_chan].mode,
                                   slot_stat[in_chan].int_en};
        REG_STATUS:   read_data = {{(DATA_W-3){1'b0}}, slot_stat[in_chan].in_use,
                                   slot_stat[in_chan].running,
                                   slot_stat[in_chan].tflag};
        REG_IDLE:     read_data = {{(DATA_W-CHAN_ID_W-4){1'b0}}, idle_id, 4'b0000};
        REG_IRQ:      read_data = {{(DATA_W-NUM_CHANNELS){1'b0}}, tflag_vec};
        REG_COUNT:    read_data = slot_count[in_chan];
        default:      read_data = '0;
      endcase
    end
  end

  // Result register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (advance) begin
      out_valid <= 1'b1;
    end else if (m_axis_tready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      out_read_data <= read_data;
      out_irq       <= irq_lines;
    end
  end

  assign m_axis_tvalid = out_valid;
  assign m_axis_tdata  = {{(OUT_TDATA_W-DATA_W-IRQ_W){1'b0}}, out_irq, out_read_data};

  // An empty input register always takes a beat
  a_ready_when_empty: assert property (@(posedge clk) disable iff (rst)
    !in_valid |-> s_axis_tready)
    else $error("input register empty but not ready");

  // An idle read claims at most one channel
  a_one_claim: assert property (@(posedge clk) disable iff (rst)
    $onehot0(claim_vec))
    else $error("more than one channel claimed");

  // Claims happen only in multitask mode
  a_claim_mode: assert property (@(posedge clk) disable iff (rst)
    (claim_vec != '0) |-> multitask)
    else $error("channel claimed outside multitask mode");

  // Ticks and writes return zero read data
  a_zero_nonread: assert property (@(posedge clk) disable iff (rst)
    (advance && !is_read) |=> (out_read_data == '0))
    else $error("nonzero read data for a non-read beat");

endmodule
`default_nettype wire
